// ===== sv/dpw_pkg.sv =====
// ----------------------------------------------------------------------------
// dpw_pkg: shared types and constants for the depth pixel to world point block
// Register map, configuration layout and the datapath widths of the pipeline.
// ----------------------------------------------------------------------------
package dpw_pkg;

	// pixel index width; column and row ports carry this many bits
	localparam int PIX_W     = 12;
	localparam int RAW_W     = 16;
	localparam int UNIT_W    = 24;
	localparam int IF_W      = 24;
	localparam int PP_W      = 16;
	localparam int COEF_W    = 16;
	localparam int OUT_W     = 26;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 64;

	// raw count times metres per count, Q.24
	localparam int DQ24_W = RAW_W + UNIT_W;
	// kept depth in Q.16, at most depth_max plus a tenth of a metre
	localparam int DQ16_W = UNIT_W + 1;
	// pixel offset from the principal point, Q.4, signed
	localparam int DU_W   = ((PIX_W + 4 > PP_W) ? PIX_W + 4 : PP_W) + 1;
	localparam int RP_W   = DU_W + IF_W + 1;
	localparam int RAY_W  = RP_W - 12;
	localparam int PY_W   = RAY_W + DQ16_W + 1;
	localparam int S_W    = PY_W - 16 + 1;
	localparam int P_W    = COEF_W + S_W;
	localparam int A_W    = P_W + 2;

	// one tenth of a metre in Q.16, rounded to nearest
	localparam int TENTH_Q16 = 6554;
	localparam int OUT_MAX   = 33554431;
	localparam int OUT_MIN   = -33554432;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEPTH_UNIT      = 4'd0,
		REG_DEPTH_MIN       = 4'd1,
		REG_DEPTH_MAX       = 4'd2,
		REG_PRINCIPAL_POINT = 4'd3,
		REG_INVERSE_FOCAL   = 4'd4,
		REG_ROW_X           = 4'd5,
		REG_ROW_Y           = 4'd6,
		REG_ROW_Z           = 4'd7
	} reg_idx_t;

	// one transform row, packed as in the register
	typedef struct packed {
		logic signed [COEF_W-1:0] t;
		logic signed [COEF_W-1:0] r2;
		logic signed [COEF_W-1:0] r1;
		logic signed [COEF_W-1:0] r0;
	} row_t;

	typedef struct packed {
		logic [PP_W-1:0] cy;
		logic [PP_W-1:0] cx;
	} pp_t;

	typedef struct packed {
		logic [IF_W-1:0] ify;
		logic [IF_W-1:0] ifx;
	} ifocal_t;

	typedef struct packed {
		logic [UNIT_W-1:0] depth_unit;
		logic [UNIT_W-1:0] depth_min;
		logic [UNIT_W-1:0] depth_max;
		pp_t               pp;
		ifocal_t           ifocal;
		row_t [2:0]        rows;
	} cfg_t;

	localparam logic [UNIT_W-1:0] RST_DEPTH_UNIT = 24'd16777;
	localparam logic [UNIT_W-1:0] RST_DEPTH_MIN  = 24'd0;
	localparam logic [UNIT_W-1:0] RST_DEPTH_MAX  = 24'd327680;
	localparam logic [31:0]       RST_PP         = 32'h0F00_0000;
	localparam logic [47:0]       RST_IFOCAL     = 48'd0;
	localparam logic [63:0]       RST_ROW_X      = 64'h0000_0000_0000_4000;
	localparam logic [63:0]       RST_ROW_Y      = 64'h0000_0000_4000_0000;
	localparam logic [63:0]       RST_ROW_Z      = 64'h0000_4000_0000_0000;

endpackage

// ===== sv/depth_pixel_to_world_point.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point: depth pixel back-projection to a world point
// Scales raw depth, drops out-of-range pixels, back-projects through the
// pinhole intrinsics and applies the sensor to world transform.
// ----------------------------------------------------------------------------
// The block takes one pixel item per clock unless the point channel stalls, and
// returns its world point from a seven-stage pipeline whose last stage is the output
// register. Pixels whose nonzero depth falls outside [depth_min, depth_max]
// leave the pipeline at stage two and give no point; a raw depth of zero gives
// a point at depth_max plus 0.1 m with no_return set. A stall on the point
// channel freezes every stage while the output register holds a point, and is
// passed back to the pixel channel in the same cycle. The user must write registers
// only while no item is in flight; the block itself does not enforce this.
module depth_pixel_to_world_point import dpw_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DAT_W-1:0]        cfg_data,
	// pixel channel
	input  logic                        pixel_valid,
	output logic                        pixel_stall,
	input  logic [PIX_W-1:0]            column,
	input  logic [PIX_W-1:0]            image_row,
	input  logic [RAW_W-1:0]            depth_raw,
	// point channel
	output logic                        point_valid,
	input  logic                        point_stall,
	output logic signed [OUT_W-1:0]     point_x,
	output logic signed [OUT_W-1:0]     point_y,
	output logic signed [OUT_W-1:0]     point_z,
	output logic                        no_return
);

	localparam logic signed [RP_W-1:0] HALF_RAY = RP_W'(2048);
	localparam logic signed [PY_W-1:0] HALF_PY  = PY_W'(32768);
	localparam logic signed [A_W-1:0]  HALF_W   = A_W'(8192);
	localparam logic signed [A_W-1:0]  SAT_HI   = A_W'(OUT_MAX);
	localparam logic signed [A_W-1:0]  SAT_LO   = A_W'(OUT_MIN);

	cfg_t cfg;

	dpw_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// pipeline advances unless a finished point is held
	logic adv;
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6, vo_q;

	assign adv         = !(vo_q && point_stall);
	assign pixel_stall = !adv;
	assign point_valid = vo_q;

	// stage 1: depth scale and pixel offsets times inverse focal lengths
	logic signed [DU_W-1:0] du, dv;
	logic [DQ24_W-1:0]      dq24_s1;
	logic signed [RP_W-1:0] pu_s1, pv_s1;
	logic                   nr_s1;

	assign du = $signed(DU_W'({column, 4'b0000})) - $signed(DU_W'(cfg.pp.cx));
	assign dv = $signed(DU_W'({image_row, 4'b0000})) - $signed(DU_W'(cfg.pp.cy));

	always_ff @(posedge clk) begin
		if (adv) begin
			dq24_s1 <= DQ24_W'(depth_raw) * DQ24_W'(cfg.depth_unit);
			pu_s1   <= RP_W'(du) * RP_W'($signed({1'b0, cfg.ifocal.ifx}));
			pv_s1   <= RP_W'(dv) * RP_W'($signed({1'b0, cfg.ifocal.ify}));
			nr_s1   <= (depth_raw == '0);
		end
	end

	// stage 2: range check, no-return substitution, round depth and rays
	logic [DQ24_W-1:0]       dq24_m, dq24_r;
	logic                    keep;
	logic signed [RP_W-1:0]  pu_r, pv_r;
	logic [DQ16_W-1:0]       dq16_s2;
	logic signed [RAY_W-1:0] ru_s2, rv_s2;
	logic                    nr_s2;

	always_comb begin
		dq24_m = nr_s1 ?
			DQ24_W'({25'(cfg.depth_max) + 25'(TENTH_Q16), 8'b0}) : dq24_s1;
		keep   = nr_s1 ||
			((dq24_s1 >= DQ24_W'({cfg.depth_min, 8'b0})) &&
			 (dq24_s1 <= DQ24_W'({cfg.depth_max, 8'b0})));
		dq24_r = dq24_m + DQ24_W'(128);
		pu_r   = pu_s1 + HALF_RAY;
		pv_r   = pv_s1 + HALF_RAY;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dq16_s2 <= dq24_r[DQ16_W+7:8];
			ru_s2   <= $signed(pu_r[RP_W-1:12]);
			rv_s2   <= $signed(pv_r[RP_W-1:12]);
			nr_s2   <= nr_s1;
		end
	end

	// stage 3: scale the rays by depth
	logic signed [PY_W-1:0] py_s3, pz_s3;
	logic [DQ16_W-1:0]      dq16_s3;
	logic                   nr_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			py_s3   <= PY_W'(ru_s2) * PY_W'($signed({1'b0, dq16_s2}));
			pz_s3   <= PY_W'(rv_s2) * PY_W'($signed({1'b0, dq16_s2}));
			dq16_s3 <= dq16_s2;
			nr_s3   <= nr_s2;
		end
	end

	// stage 4: round and flip into the sensor frame (y left, z up)
	logic signed [PY_W-1:0]  py_r, pz_r;
	logic signed [S_W-1:0]   sx_s4, sy_s4, sz_s4;
	logic                    nr_s4;

	always_comb begin
		py_r = py_s3 + HALF_PY;
		pz_r = pz_s3 + HALF_PY;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s4 <= S_W'($signed({1'b0, dq16_s3}));
			sy_s4 <= -S_W'($signed(py_r[PY_W-1:16]));
			sz_s4 <= -S_W'($signed(pz_r[PY_W-1:16]));
			nr_s4 <= nr_s3;
		end
	end

	// stage 5: rotation products and translation, one lane per axis
	logic signed [P_W-1:0] px_s5 [3];
	logic signed [P_W-1:0] pyw_s5 [3];
	logic signed [P_W-1:0] pzw_s5 [3];
	logic signed [P_W-1:0] tr_s5 [3];
	logic                  nr_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				px_s5[i]  <= P_W'(cfg.rows[i].r0) * P_W'(sx_s4);
				pyw_s5[i] <= P_W'(cfg.rows[i].r1) * P_W'(sy_s4);
				pzw_s5[i] <= P_W'(cfg.rows[i].r2) * P_W'(sz_s4);
				tr_s5[i]  <= P_W'($signed({cfg.rows[i].t, 22'b0}));
			end
			nr_s5 <= nr_s4;
		end
	end

	// stage 6: accumulate each lane
	logic signed [A_W-1:0] acc_s6 [3];
	logic                  nr_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				acc_s6[i] <= A_W'(px_s5[i]) + A_W'(pyw_s5[i]) +
					A_W'(pzw_s5[i]) + A_W'(tr_s5[i]);
			end
			nr_s6 <= nr_s5;
		end
	end

	// stage 7: round to Q.16 and saturate into the output register
	logic signed [A_W-1:0]   wr [3];
	logic signed [A_W-1:0]   wsh [3];
	logic signed [OUT_W-1:0] wsat [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wr[i]  = acc_s6[i] + HALF_W;
			wsh[i] = wr[i] >>> 14;
			if (wsh[i] > SAT_HI) begin
				wsat[i] = SAT_HI[OUT_W-1:0];
			end else if (wsh[i] < SAT_LO) begin
				wsat[i] = SAT_LO[OUT_W-1:0];
			end else begin
				wsat[i] = wsh[i][OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point_x   <= wsat[0];
			point_y   <= wsat[1];
			point_z   <= wsat[2];
			no_return <= nr_s6;
		end
	end

	// advance valid bits; drop rejected pixels at stage two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
			vo_q  <= 1'b0;
		end else if (adv) begin
			v1_s1 <= pixel_valid;
			v2_s2 <= v1_s1 && keep;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			v5_s5 <= v4_s4;
			v6_s6 <= v5_s5;
			vo_q  <= v6_s6;
		end
	end

endmodule

// ===== sv/dpw_regs.sv =====
// ----------------------------------------------------------------------------
// dpw_regs: configuration register file
// Decodes register writes and holds the camera intrinsics, depth limits and
// the combined sensor to world transform.
// ----------------------------------------------------------------------------
module dpw_regs import dpw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// writes never wait
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// decode the index; drop writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_unit <= RST_DEPTH_UNIT;
			cfg_q.depth_min  <= RST_DEPTH_MIN;
			cfg_q.depth_max  <= RST_DEPTH_MAX;
			cfg_q.pp         <= RST_PP;
			cfg_q.ifocal     <= RST_IFOCAL;
			cfg_q.rows[0]    <= RST_ROW_X;
			cfg_q.rows[1]    <= RST_ROW_Y;
			cfg_q.rows[2]    <= RST_ROW_Z;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEPTH_UNIT:      cfg_q.depth_unit <= cfg_data[UNIT_W-1:0];
				REG_DEPTH_MIN:       cfg_q.depth_min  <= cfg_data[UNIT_W-1:0];
				REG_DEPTH_MAX:       cfg_q.depth_max  <= cfg_data[UNIT_W-1:0];
				REG_PRINCIPAL_POINT: cfg_q.pp         <= cfg_data[31:0];
				REG_INVERSE_FOCAL:   cfg_q.ifocal     <= cfg_data[47:0];
				REG_ROW_X:           cfg_q.rows[0]    <= cfg_data;
				REG_ROW_Y:           cfg_q.rows[1]    <= cfg_data;
				REG_ROW_Z:           cfg_q.rows[2]    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== dv/dpw_point_checker.sv =====
// ----------------------------------------------------------------------------
// dpw_point_checker: scoreboard for the depth pixel to world point block
// Tracks register writes, predicts the world point of every accepted pixel
// and compares each accepted point field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dpw_point_checker import dpw_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DAT_W-1:0]    cfg_data,
	input  logic                    pixel_valid,
	input  logic                    pixel_stall,
	input  logic [PIX_W-1:0]        column,
	input  logic [PIX_W-1:0]        image_row,
	input  logic [RAW_W-1:0]        depth_raw,
	input  logic                    point_valid,
	input  logic                    point_stall,
	input  logic signed [OUT_W-1:0] point_x,
	input  logic signed [OUT_W-1:0] point_y,
	input  logic signed [OUT_W-1:0] point_z,
	input  logic                    no_return,
	output int                      fail_count,
	output int                      pending
);

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] z;
		logic                    nr;
	} world_pt_t;

	// shadow copy of the register file
	logic [UNIT_W-1:0] unit_q;
	logic [UNIT_W-1:0] min_q;
	logic [UNIT_W-1:0] max_q;
	pp_t               pp_q;
	ifocal_t           focal_q;
	row_t              rows_q [3];

	world_pt_t         expected_points [$];
	world_pt_t         got_pt;
	world_pt_t         want_pt;

	// round half up by s bits; >>> on a signed longint floors
	function automatic longint round_down(longint a, int s);
		return (a + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// one world axis: rotate, translate, round to Q.16 and saturate
	function automatic logic signed [OUT_W-1:0] world_axis(row_t r, longint sx, longint sy,
			longint sz);
		longint acc;
		longint w;
		acc = longint'($signed(r.r0)) * sx + longint'($signed(r.r1)) * sy
		    + longint'($signed(r.r2)) * sz + (longint'($signed(r.t)) <<< 22);
		w = round_down(acc, 14);
		if (w > longint'(OUT_MAX))
			w = longint'(OUT_MAX);
		if (w < longint'(OUT_MIN))
			w = longint'(OUT_MIN);
		return w[OUT_W-1:0];
	endfunction

	// back-project one pixel; return 0 when the depth is out of range
	function automatic bit project_pixel(logic [PIX_W-1:0] u, logic [PIX_W-1:0] v,
			logic [RAW_W-1:0] raw, output world_pt_t pt);
		longint dq24;
		longint dq16;
		longint du;
		longint dv;
		longint rayu;
		longint rayv;
		longint sy;
		longint sz;
		bit     nr;
		pt = '0;
		nr = (raw == '0);
		if (nr) begin
			dq24 = (longint'(max_q) + TENTH_Q16) <<< 8;
		end else begin
			dq24 = longint'(raw) * longint'(unit_q);
			if (dq24 < (longint'(min_q) <<< 8))
				return 1'b0;
			if (dq24 > (longint'(max_q) <<< 8))
				return 1'b0;
		end
		dq16 = (dq24 + 128) >>> 8;
		du   = (longint'(u) <<< 4) - longint'(pp_q.cx);
		dv   = (longint'(v) <<< 4) - longint'(pp_q.cy);
		rayu = round_down(du * longint'(focal_q.ifx), 12);
		rayv = round_down(dv * longint'(focal_q.ify), 12);
		sy   = -round_down(rayu * dq16, 16);
		sz   = -round_down(rayv * dq16, 16);
		pt.x  = world_axis(rows_q[0], dq16, sy, sz);
		pt.y  = world_axis(rows_q[1], dq16, sy, sz);
		pt.z  = world_axis(rows_q[2], dq16, sy, sz);
		pt.nr = nr;
		return 1'b1;
	endfunction

	task automatic check_field(string name, logic signed [OUT_W-1:0] want,
			logic signed [OUT_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q     = RST_DEPTH_UNIT;
			min_q      = RST_DEPTH_MIN;
			max_q      = RST_DEPTH_MAX;
			pp_q       = RST_PP;
			focal_q    = RST_IFOCAL;
			rows_q[0]  = RST_ROW_X;
			rows_q[1]  = RST_ROW_Y;
			rows_q[2]  = RST_ROW_Z;
			fail_count = 0;
			expected_points.delete();
			pending <= 0;
		end else begin
			// mirror register writes, masked to each register's width
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEPTH_UNIT:      unit_q    = cfg_data[UNIT_W-1:0];
					REG_DEPTH_MIN:       min_q     = cfg_data[UNIT_W-1:0];
					REG_DEPTH_MAX:       max_q     = cfg_data[UNIT_W-1:0];
					REG_PRINCIPAL_POINT: pp_q      = cfg_data[31:0];
					REG_INVERSE_FOCAL:   focal_q   = cfg_data[47:0];
					REG_ROW_X:           rows_q[0] = cfg_data;
					REG_ROW_Y:           rows_q[1] = cfg_data;
					REG_ROW_Z:           rows_q[2] = cfg_data;
					default: ;
				endcase
			end

			// compare a delivered point with the oldest prediction
			if (point_valid && !point_stall) begin
				if (expected_points.size() == 0) begin
					$error("point (%0d, %0d, %0d) arrived with no pending expectation",
						point_x, point_y, point_z);
					fail_count++;
				end else begin
					want_pt = expected_points.pop_front();
					check_field("point_x", want_pt.x, point_x);
					check_field("point_y", want_pt.y, point_y);
					check_field("point_z", want_pt.z, point_z);
					check_field("no_return", $signed(OUT_W'(want_pt.nr)),
						$signed(OUT_W'(no_return)));
				end
			end

			// predict the point of an accepted pixel
			if (pixel_valid && !pixel_stall) begin
				if (project_pixel(column, image_row, depth_raw, got_pt))
					expected_points.insert(expected_points.size(), got_pt);
			end

			pending <= expected_points.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for depth_pixel_to_world_point
// Drives directed corner pixels and register settings, then random pixel
// streams under random idling, with one long output hold in phases 1 and 4.
// ----------------------------------------------------------------------------
module testbench;
	import dpw_pkg::*;

	localparam int CYCLE_LIMIT      = 200000;
	localparam int DRAIN_CYCLES     = 16;
	localparam int LONG_HOLD_CYCLES = 64;
	localparam int RANDOM_PHASES    = 6;
	localparam int PHASE_ITEMS      = 250;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DAT_W-1:0]    cfg_data;
	logic                    pixel_valid;
	logic                    pixel_stall;
	logic [PIX_W-1:0]        column;
	logic [PIX_W-1:0]        image_row;
	logic [RAW_W-1:0]        depth_raw;
	logic                    point_valid;
	logic                    point_stall;
	logic signed [OUT_W-1:0] point_x;
	logic signed [OUT_W-1:0] point_y;
	logic signed [OUT_W-1:0] point_z;
	logic                    no_return;

	int          fail_count;
	int          pending;
	int          tx_idle_max = 5;
	int          rx_idle_max = 5;
	bit          hold_req    = 1'b0;
	int unsigned cycle_cnt   = 0;

	// current depth settings, used only to steer random depths into range
	longint      cur_unit = RST_DEPTH_UNIT;
	longint      cur_min  = RST_DEPTH_MIN;
	longint      cur_max  = RST_DEPTH_MAX;

	depth_pixel_to_world_point dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.column      (column),
		.image_row   (image_row),
		.depth_raw   (depth_raw),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.no_return   (no_return)
	);

	dpw_point_checker point_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.column      (column),
		.image_row   (image_row),
		.depth_raw   (depth_raw),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.no_return   (no_return),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// end the run with a failure once the cycle limit is reached
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Verification failed");
		$finish;
	end

	// point receiver: random stalls per item, long hold on request
	initial begin : point_receiver
		int wait_cycles;
		point_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req    = 1'b0;
				wait_cycles = LONG_HOLD_CYCLES;
			end else begin
				wait_cycles = $urandom_range(0, rx_idle_max);
			end
			if (wait_cycles > 0) begin
				point_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				point_stall <= 1'b0;
			end
			do @(posedge clk); while (!(point_valid && !point_stall));
		end
	end

	// fill the bits above a register's width with noise
	function automatic logic [CFG_DAT_W-1:0] with_noise(logic [CFG_DAT_W-1:0] value, int width);
		logic [CFG_DAT_W-1:0] noise;
		noise = {$urandom, $urandom};
		return (noise << width) | value;
	endfunction

	// pick a raw depth: some no-return, mostly in range, the rest anything
	function automatic logic [RAW_W-1:0] pick_depth();
		longint lo;
		longint hi;
		int     sel;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return '0;
		if (sel < 75 && cur_unit != 0) begin
			lo = (cur_min * 256 + cur_unit - 1) / cur_unit;
			hi = (cur_max * 256) / cur_unit;
			if (lo < 1)
				lo = 1;
			if (hi > 65535)
				hi = 65535;
			if (lo <= hi)
				return RAW_W'($urandom_range(int'(lo), int'(hi)));
		end
		return RAW_W'($urandom_range(0, 65535));
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// write the whole register file, plus one write to an unused index
	task automatic apply_setup(logic [UNIT_W-1:0] unit, logic [UNIT_W-1:0] dmin,
			logic [UNIT_W-1:0] dmax, logic [31:0] pp, logic [47:0] focal,
			logic [63:0] row_x, logic [63:0] row_y, logic [63:0] row_z);
		logic [CFG_IDX_W-1:0] spare_idx;
		spare_idx = CFG_IDX_W'($urandom_range(int'(REG_ROW_Z) + 1, 2**CFG_IDX_W - 1));
		write_reg(REG_DEPTH_UNIT, with_noise(unit, UNIT_W));
		write_reg(REG_DEPTH_MIN, with_noise(dmin, UNIT_W));
		write_reg(REG_DEPTH_MAX, with_noise(dmax, UNIT_W));
		write_reg(REG_PRINCIPAL_POINT, with_noise(pp, 32));
		write_reg(REG_INVERSE_FOCAL, with_noise(focal, 48));
		write_reg(REG_ROW_X, row_x);
		write_reg(REG_ROW_Y, row_y);
		write_reg(REG_ROW_Z, row_z);
		write_reg(spare_idx, {$urandom, $urandom});
		cur_unit = unit;
		cur_min  = dmin;
		cur_max  = dmax;
	endtask

	task automatic random_setup();
		logic [UNIT_W-1:0] unit;
		logic [UNIT_W-1:0] dmin;
		logic [47:0]       focal;
		if ($urandom_range(0, 3) == 0)
			unit = UNIT_W'($urandom);
		else
			unit = UNIT_W'($urandom_range(1000, 70000));
		dmin = UNIT_W'($urandom_range(0, 40000));
		if ($urandom_range(0, 1) == 0)
			focal = {24'($urandom_range(10000, 200000)), 24'($urandom_range(10000, 200000))};
		else
			focal = 48'({$urandom, $urandom});
		apply_setup(unit, dmin, UNIT_W'(dmin + $urandom_range(1, 2000000)), 32'($urandom),
			focal, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
	endtask

	// offer one pixel after a random gap and hold it until accepted
	task automatic send_pixel(logic [PIX_W-1:0] u, logic [PIX_W-1:0] v, logic [RAW_W-1:0] raw);
		int gap;
		gap = $urandom_range(0, tx_idle_max);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		column      <= u;
		image_row   <= v;
		depth_raw   <= raw;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (pixel_stall);
	endtask

	// drop valid, wait for every predicted point, then let rejects drain
	task automatic settle();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int phase;
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		pixel_valid <= 1'b0;
		column      <= '0;
		image_row   <= '0;
		depth_raw   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no return, range bounds, pixel extremes
		send_pixel(PIX_W'(0), PIX_W'(0), RAW_W'(0));
		send_pixel(PIX_W'(4095), PIX_W'(4095), RAW_W'(0));
		send_pixel(PIX_W'(0), PIX_W'(4095), RAW_W'(1));
		send_pixel(PIX_W'(4095), PIX_W'(0), RAW_W'(5000));
		send_pixel(PIX_W'(2048), PIX_W'(1024), RAW_W'(5001));
		send_pixel(PIX_W'(100), PIX_W'(200), RAW_W'(65535));
		settle();

		// typical camera: 1 mm units, 0.2 m to 10 m, rotated mount with offset
		apply_setup(UNIT_W'(16777), UNIT_W'(13107), UNIT_W'(655360),
			{16'(240 * 16), 16'(320 * 16)}, {24'd31957, 24'd31957},
			64'h0100_0000_C000_0000, 64'hFF80_0000_0000_4000, 64'h0040_4000_0000_0000);
		send_pixel(PIX_W'(0), PIX_W'(0), RAW_W'(1000));
		send_pixel(PIX_W'(4095), PIX_W'(4095), RAW_W'(1000));
		send_pixel(PIX_W'(320), PIX_W'(240), RAW_W'(2000));
		send_pixel(PIX_W'(0), PIX_W'(0), RAW_W'(0));
		send_pixel(PIX_W'(4095), PIX_W'(0), RAW_W'(200));
		send_pixel(PIX_W'(0), PIX_W'(4095), RAW_W'(199));
		send_pixel(PIX_W'(1234), PIX_W'(567), RAW_W'(65535));
		settle();

		// all-ones settings, saturating rows; 256 counts sit exactly on the maximum
		apply_setup('1, '0, '1, '1, '1, 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
			64'hFFFF_FFFF_FFFF_FFFF);
		send_pixel(PIX_W'(4095), PIX_W'(4095), RAW_W'(0));
		send_pixel(PIX_W'(0), PIX_W'(0), RAW_W'(0));
		send_pixel(PIX_W'(0), PIX_W'(0), RAW_W'(256));
		send_pixel(PIX_W'(4095), PIX_W'(4095), RAW_W'(257));
		send_pixel(PIX_W'(4095), PIX_W'(0), RAW_W'(1));
		send_pixel(PIX_W'(0), PIX_W'(4095), RAW_W'(255));
		settle();

		// minimum above maximum: only no-return pixels survive
		apply_setup(UNIT_W'(16777), UNIT_W'(100001), UNIT_W'(100000), 32'h0,
			48'hFFFFFF_FFFFFF, RST_ROW_X, RST_ROW_Y, RST_ROW_Z);
		send_pixel(PIX_W'(10), PIX_W'(10), RAW_W'(0));
		send_pixel(PIX_W'(10), PIX_W'(10), RAW_W'(1));
		send_pixel(PIX_W'(10), PIX_W'(10), RAW_W'(65535));
		send_pixel(PIX_W'(4095), PIX_W'(4095), RAW_W'(5960));
		settle();

		// all-zero settings: every nonzero depth collapses to zero and is kept
		apply_setup('0, '0, '0, '0, '0, '0, '0, '0);
		send_pixel(PIX_W'(4095), PIX_W'(4095), RAW_W'(65535));
		send_pixel(PIX_W'(0), PIX_W'(0), RAW_W'(0));
		send_pixel(PIX_W'(0), PIX_W'(0), RAW_W'(1));
		settle();

		// random settings and pixel streams under varied idling
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_setup();
			tx_idle_max = (phase % 3 == 0) ? 0 : 5;
			rx_idle_max = (phase % 2 == 0) ? 5 : 0;
			if (phase == 1 || phase == 4) begin
				tx_idle_max = 0;
				hold_req    = 1'b1;
			end
			repeat (PHASE_ITEMS)
				send_pixel(PIX_W'($urandom), PIX_W'($urandom), pick_depth());
			settle();
		end

		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
